[sv/ptl_pkg.sv]
// Shared types, constants and helpers for the proportional text layout block.
package ptl_pkg;

   // Character codes with a fixed meaning
   localparam logic [7:0] CODE_NEWLINE    = 8'd10;
   localparam logic [7:0] CODE_SPACE      = 8'd32;
   localparam logic [7:0] FIRST_PRINTABLE = 8'd33;

   // Highest blit mode that yields a draw command
   localparam logic [2:0] MODE_MAX = 3'd4;

   // Atlas extent; source coordinates clamp to ATLAS_SIZE-1
   localparam int ATLAS_SIZE = 1024;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes on the csr port
   localparam logic [1:0] CSR_GLYPH_SPACING = 2'd0;
   localparam logic [1:0] CSR_SPACE_ADVANCE = 2'd1;
   localparam logic [1:0] CSR_LINE_HEIGHT   = 2'd2;

   // What the back end does with an item
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_WRITE,
      KIND_SPACE,
      KIND_NEWLINE,
      KIND_GLYPH
   } kind_type;

   // One glyph table entry
   typedef struct packed {
      logic [9:0] src_x;
      logic [9:0] src_y;
      logic [7:0] width;
      logic [7:0] height;
   } glyph_type;

   // Classified item handed from front to back
   typedef struct packed {
      kind_type          kind;
      logic              first;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [7:0]        gindex;
      glyph_type         entry;
      logic              mode_ok;
      logic [2:0]        mode;
      logic [15:0]       color;
   } cmd_type;

   // Layout registers
   typedef struct packed {
      logic signed [5:0] spacing;
      logic [7:0]        space_adv;
      logic [7:0]        line_h;
   } csr_type;

   // Saturate a widened pen coordinate to signed 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[sv/proportional_text_layout.sv]
// Top level of the proportional bitmap font text layout block.
// Takes one item per cycle while the result side does not stall, and gives
// one result per item. A glyph write stores the atlas rectangle of one
// glyph; a character item moves the pen and, for a printable code in the
// glyph table with a known blit mode, returns a blit command at the pen
// position. The accepting edge loads the decode register in the front end,
// then the item passes a two-entry command queue and the registered glyph
// table read, and lands in the result register, where the pen addition
// also lands. The pen update runs in the same cycle as the result, so items
// follow back to back. The glyph table reads as zero until an entry is
// written; there is no clearing pass after reset. The user must write the
// layout registers on the csr port only while no item is in flight; the
// block itself does not enforce this.
module proportional_text_layout #(
   parameter int GLYPH_COUNT = 96
) (
   input  logic         clock,
   input  logic         reset,
   // Layout registers
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data,
   // Input items
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata from bit 0: origin_x[16], origin_y[16], char_code[8], blit_mode[3],
   // tint_color[16], glyph_slot[7], glyph_src_x[10], glyph_src_y[10],
   // glyph_width[8], glyph_height[8], zero pad[2]
   input  logic [103:0] req_tdata,
   // req_tuser from bit 0: func, first_of_string
   input  logic [1:0]   req_tuser,
   // Result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata from bit 0: dest_x[16], dest_y[16], source_x[10], source_y[10],
   // rect_width[8], rect_height[8], draw_mode[3], draw_color[16], zero pad[1]
   output logic [87:0]  rsp_tdata,
   // rsp_tuser: draw_valid
   output logic         rsp_tuser
);
   import ptl_pkg::*;

   csr_type csr_ff;
   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   cmd_type fq_cmd, qb_cmd;

   logic        draw_valid;
   logic [15:0] dest_x, dest_y, draw_color;
   logic [9:0]  source_x, source_y;
   logic [7:0]  rect_width, rect_height;
   logic [2:0]  draw_mode;

   // Write layout registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GLYPH_SPACING: csr_ff.spacing   <= csr_data[5:0];
            CSR_SPACE_ADVANCE: csr_ff.space_adv <= csr_data;
            CSR_LINE_HEIGHT:   csr_ff.line_h    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ptl_front #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .func            (req_tuser[0]),
      .first_of_string (req_tuser[1]),
      .origin_x        (req_tdata[15:0]),
      .origin_y        (req_tdata[31:16]),
      .char_code       (req_tdata[39:32]),
      .blit_mode       (req_tdata[42:40]),
      .tint_color      (req_tdata[58:43]),
      .glyph_slot      (req_tdata[65:59]),
      .glyph_src_x     (req_tdata[75:66]),
      .glyph_src_y     (req_tdata[85:76]),
      .glyph_width     (req_tdata[93:86]),
      .glyph_height    (req_tdata[101:94]),
      .out_valid       (fq_valid),
      .out_ready       (fq_ready),
      .out_cmd         (fq_cmd)
   );

   ptl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   ptl_back #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .cmd_valid   (qb_valid),
      .cmd_ready   (qb_ready),
      .cmd         (qb_cmd),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .draw_valid  (draw_valid),
      .dest_x      (dest_x),
      .dest_y      (dest_y),
      .source_x    (source_x),
      .source_y    (source_y),
      .rect_width  (rect_width),
      .rect_height (rect_height),
      .draw_mode   (draw_mode),
      .draw_color  (draw_color)
   );

   // Pack the result
   assign rsp_tuser = draw_valid;
   assign rsp_tdata = {1'b0, draw_color, draw_mode, rect_height, rect_width,
                       source_y, source_x, dest_y, dest_x};

endmodule

[sv/ptl_front.sv]
// Front end: accepts input items, decodes and classifies them into commands.
module ptl_front #(
   parameter int GLYPH_COUNT = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic             func,
   input  logic             first_of_string,
   input  logic [15:0]      origin_x,
   input  logic [15:0]      origin_y,
   input  logic [7:0]       char_code,
   input  logic [2:0]       blit_mode,
   input  logic [15:0]      tint_color,
   input  logic [6:0]       glyph_slot,
   input  logic [9:0]       glyph_src_x,
   input  logic [9:0]       glyph_src_y,
   input  logic [7:0]       glyph_width,
   input  logic [7:0]       glyph_height,
   output logic             out_valid,
   input  logic             out_ready,
   output ptl_pkg::cmd_type out_cmd
);
   import ptl_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic [7:0] gdiff;
   logic       slot_ok;
   logic       glyph_ok;
   logic       take;

   // Clamp an atlas coordinate to the atlas extent
   function automatic logic [9:0] clamp_atlas(input logic [9:0] v);
      logic [9:0] r;
      if ({3'b000, v} > 13'(ATLAS_SIZE - 1)) begin
         r = 10'(ATLAS_SIZE - 1);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign take     = in_valid && in_ready;
   assign in_ready = !valid_ff || out_ready;

   // Decode the item
   assign gdiff    = char_code - FIRST_PRINTABLE;
   assign slot_ok  = {2'b00, glyph_slot} < 9'(GLYPH_COUNT);
   assign glyph_ok = (char_code >= FIRST_PRINTABLE) && ({1'b0, gdiff} < 9'(GLYPH_COUNT));

   always_comb begin
      cmd_in              = cmd_ff;
      valid_in            = valid_ff;
      if (take) begin
         valid_in            = 1'b1;
         cmd_in.first        = func && first_of_string;
         cmd_in.origin_x     = origin_x;
         cmd_in.origin_y     = origin_y;
         cmd_in.entry.src_x  = clamp_atlas(glyph_src_x);
         cmd_in.entry.src_y  = clamp_atlas(glyph_src_y);
         cmd_in.entry.width  = glyph_width;
         cmd_in.entry.height = glyph_height;
         cmd_in.mode_ok      = blit_mode <= MODE_MAX;
         cmd_in.mode         = blit_mode;
         cmd_in.color        = tint_color;
         cmd_in.gindex       = func ? gdiff : {1'b0, glyph_slot};
         priority if (!func) begin
            cmd_in.kind = slot_ok ? KIND_WRITE : KIND_NONE;
         end else if (char_code == CODE_SPACE) begin
            cmd_in.kind = KIND_SPACE;
         end else if (char_code == CODE_NEWLINE) begin
            cmd_in.kind = KIND_NEWLINE;
         end else if (glyph_ok) begin
            cmd_in.kind = KIND_GLYPH;
         end else begin
            cmd_in.kind = KIND_NONE;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // Hold the classified item until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign out_valid = valid_ff;
   assign out_cmd   = cmd_ff;

endmodule

[sv/ptl_queue.sv]
// Short command queue between the front and back ends.
module ptl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ptl_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ptl_pkg::cmd_type pop_cmd
);
   import ptl_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/ptl_back.sv]
// Back end: glyph table, pen state and the registered result.
module ptl_back #(
   parameter int GLYPH_COUNT = 96
) (
   input  logic              clock,
   input  logic              reset,
   input  ptl_pkg::csr_type  csr,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ptl_pkg::cmd_type  cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              draw_valid,
   output logic [15:0]       dest_x,
   output logic [15:0]       dest_y,
   output logic [9:0]        source_x,
   output logic [9:0]        source_y,
   output logic [7:0]        rect_width,
   output logic [7:0]        rect_height,
   output logic [2:0]        draw_mode,
   output logic [15:0]       draw_color
);
   import ptl_pkg::*;

   localparam int GW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   // Glyph table with per-entry valid bits
   glyph_type          mem [GLYPH_COUNT];
   logic [GLYPH_COUNT-1:0] gvalid_ff;
   glyph_type          rd_data_ff;
   logic               rd_valid_ff;
   logic [GW-1:0]      gidx;

   // Lookup stage
   logic    s1_valid_ff;
   cmd_type s1_cmd_ff;
   logic    pop, s1_adv;

   // Pen state
   logic signed [15:0] pen_x_ff, pen_x_in;
   logic signed [15:0] pen_y_ff, pen_y_in;
   logic signed [15:0] lsx_ff, lsx_in;

   // Result register
   logic        rsp_valid_ff;
   logic        draw_ff, draw_in;
   logic [15:0] dx_ff, dx_in, dy_ff, dy_in;
   glyph_type   rect_ff, rect_in;
   logic [2:0]  mode_ff, mode_in;
   logic [15:0] color_ff, color_in;

   logic signed [15:0] px0, py0, ls0;
   glyph_type          g;
   logic signed [17:0] spc18, sum_space, sum_glyph, sum_line;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || out_ready);
   assign pop       = cmd_valid && (!s1_valid_ff || s1_adv);
   assign cmd_ready = !s1_valid_ff || s1_adv;
   assign gidx      = cmd.gindex[GW-1:0];

   // Write or read the glyph table as a command leaves the queue
   always_ff @(posedge clock) begin
      if (pop && (cmd.kind == KIND_WRITE)) begin
         mem[gidx] <= cmd.entry;
      end
      if (pop && (cmd.kind == KIND_GLYPH)) begin
         rd_data_ff <= mem[gidx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gvalid_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (pop && (cmd.kind == KIND_WRITE)) begin
            gvalid_ff[gidx] <= 1'b1;
         end
         if (pop && (cmd.kind == KIND_GLYPH)) begin
            rd_valid_ff <= gvalid_ff[gidx];
         end
      end
   end

   // Advance the lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pop) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (pop) begin
         s1_cmd_ff <= cmd;
      end
   end

   // Pen update and result for the command in the lookup stage
   always_comb begin
      px0   = s1_cmd_ff.first ? s1_cmd_ff.origin_x : pen_x_ff;
      py0   = s1_cmd_ff.first ? s1_cmd_ff.origin_y : pen_y_ff;
      ls0   = s1_cmd_ff.first ? s1_cmd_ff.origin_x : lsx_ff;
      g     = rd_valid_ff ? rd_data_ff : '0;
      spc18 = {{12{csr.spacing[5]}}, csr.spacing};
      sum_space = {{2{px0[15]}}, px0} + $signed({10'b0, csr.space_adv}) + spc18;
      sum_glyph = {{2{px0[15]}}, px0} + $signed({10'b0, g.width}) + spc18;
      sum_line  = {{2{py0[15]}}, py0} + $signed({10'b0, csr.line_h});

      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      lsx_in   = lsx_ff;
      draw_in  = 1'b0;
      if (s1_adv && (s1_cmd_ff.kind != KIND_WRITE)) begin
         pen_x_in = px0;
         pen_y_in = py0;
         lsx_in   = ls0;
         unique case (s1_cmd_ff.kind)
            KIND_SPACE: begin
               pen_x_in = sat16(sum_space);
            end
            KIND_NEWLINE: begin
               pen_x_in = ls0;
               pen_y_in = sat16(sum_line);
            end
            KIND_GLYPH: begin
               pen_x_in = sat16(sum_glyph);
               draw_in  = s1_cmd_ff.mode_ok;
            end
            default: begin
            end
         endcase
      end
      dx_in    = draw_in ? px0 : '0;
      dy_in    = draw_in ? py0 : '0;
      rect_in  = draw_in ? g : '0;
      mode_in  = draw_in ? s1_cmd_ff.mode : '0;
      color_in = draw_in ? s1_cmd_ff.color : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         lsx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         lsx_ff   <= lsx_in;
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_adv) begin
         draw_ff  <= draw_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         rect_ff  <= rect_in;
         mode_ff  <= mode_in;
         color_ff <= color_in;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign draw_valid  = draw_ff;
   assign dest_x      = dx_ff;
   assign dest_y      = dy_ff;
   assign source_x    = rect_ff.src_x;
   assign source_y    = rect_ff.src_y;
   assign rect_width  = rect_ff.width;
   assign rect_height = rect_ff.height;
   assign draw_mode   = mode_ff;
   assign draw_color  = color_ff;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the proportional text layout block.
module tb_top;
   import ptl_pkg::*;

   localparam int GLYPH_COUNT  = 96;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_MAX   = 10;

   // Item function carried in tuser bit 0
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LAYOUT = 1'b1;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_KEY,
      MODE_ADD,
      MODE_SUBTRACT,
      MODE_TINT
   } blit_mode_type;

   typedef struct packed {
      logic               func;
      logic               first;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [7:0]         code;
      logic [2:0]         mode;
      logic [15:0]        tint;
      logic [6:0]         slot;
      logic [9:0]         src_x;
      logic [9:0]         src_y;
      logic [7:0]         width;
      logic [7:0]         height;
   } char_item_type;

   typedef struct packed {
      logic               draw;
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic [9:0]         src_x;
      logic [9:0]         src_y;
      logic [7:0]         width;
      logic [7:0]         height;
      logic [2:0]         mode;
      logic [15:0]        color;
   } blit_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index  = '0;
   logic [7:0]   csr_data   = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic         rsp_tuser;

   // Layout registers and pen state as the block should hold them
   logic signed [5:0]  lay_spacing;
   logic [7:0]         lay_space_adv;
   logic [7:0]         lay_line_h;
   logic signed [15:0] pen_x;
   logic signed [15:0] pen_y;
   logic signed [15:0] line_x;
   logic [9:0]         glyph_sx [GLYPH_COUNT];
   logic [9:0]         glyph_sy [GLYPH_COUNT];
   logic [7:0]         glyph_w  [GLYPH_COUNT];
   logic [7:0]         glyph_h  [GLYPH_COUNT];

   blit_type expected_blits [$];

   int req_idle_pct    = 0;
   int rsp_idle_pct    = 0;
   int hold_request    = 0;
   int items_sent      = 0;
   int table_writes    = 0;
   int csr_writes      = 0;
   int results_checked = 0;
   int blits_checked   = 0;
   int mismatch_count  = 0;
   int quiet_cycles    = 0;

   proportional_text_layout #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial forever #5 clock = ~clock;

   // Clip a widened pen coordinate to signed 16 bits
   function automatic logic signed [15:0] clip_pen(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Advance the pen for one item and return the blit it should produce
   function automatic blit_type predict_layout(input char_item_type it);
      blit_type r;
      int       idx;
      r   = '0;
      idx = int'(it.code) - int'(FIRST_PRINTABLE);
      if (it.func == FUNC_WRITE) begin
         // slots past the table are dropped
         if (it.slot < GLYPH_COUNT) begin
            glyph_sx[it.slot] = (it.src_x > ATLAS_SIZE - 1) ? 10'(ATLAS_SIZE - 1) : it.src_x;
            glyph_sy[it.slot] = (it.src_y > ATLAS_SIZE - 1) ? 10'(ATLAS_SIZE - 1) : it.src_y;
            glyph_w[it.slot]  = it.width;
            glyph_h[it.slot]  = it.height;
         end
         return r;
      end
      if (it.first) begin
         pen_x  = it.origin_x;
         pen_y  = it.origin_y;
         line_x = it.origin_x;
      end
      if (it.code == CODE_SPACE) begin
         pen_x = clip_pen(int'(pen_x) + int'(lay_space_adv) + int'(lay_spacing));
      end else if (it.code == CODE_NEWLINE) begin
         pen_x = line_x;
         pen_y = clip_pen(int'(pen_y) + int'(lay_line_h));
      end else if (idx >= 0 && idx < GLYPH_COUNT) begin
         // unknown modes still advance, they just draw nothing
         if (it.mode <= MODE_MAX) begin
            r.draw   = 1'b1;
            r.dest_x = pen_x;
            r.dest_y = pen_y;
            r.src_x  = glyph_sx[idx];
            r.src_y  = glyph_sy[idx];
            r.width  = glyph_w[idx];
            r.height = glyph_h[idx];
            r.mode   = it.mode;
            r.color  = it.tint;
         end
         pen_x = clip_pen(int'(pen_x) + int'(glyph_w[idx]) + int'(lay_spacing));
      end
      return r;
   endfunction

   function automatic string describe_blit(input blit_type b);
      return $sformatf("draw=%0b dest=(%0d,%0d) src=(%0d,%0d) size=%0dx%0d mode=%0d color=%h",
                       b.draw, b.dest_x, b.dest_y, b.src_x, b.src_y, b.width, b.height,
                       b.mode, b.color);
   endfunction

   function automatic char_item_type layout_char(input logic [7:0] code, input logic first,
                                                 input logic signed [15:0] ox,
                                                 input logic signed [15:0] oy,
                                                 input logic [2:0] mode,
                                                 input logic [15:0] tint);
      char_item_type it;
      it          = '0;
      it.func     = FUNC_LAYOUT;
      it.first    = first;
      it.origin_x = ox;
      it.origin_y = oy;
      it.code     = code;
      it.mode     = mode;
      it.tint     = tint;
      return it;
   endfunction

   function automatic char_item_type glyph_write(input logic [6:0] slot, input logic [9:0] sx,
                                                 input logic [9:0] sy, input logic [7:0] w,
                                                 input logic [7:0] h);
      char_item_type it;
      it        = '0;
      it.func   = FUNC_WRITE;
      it.slot   = slot;
      it.src_x  = sx;
      it.src_y  = sy;
      it.width  = w;
      it.height = h;
      return it;
   endfunction

   // Random item: mostly text, some font updates, some stray bytes
   function automatic char_item_type random_item(input logic first);
      char_item_type it;
      int            pick;
      it       = 104'({$urandom, $urandom, $urandom, $urandom});
      pick     = $urandom_range(99);
      it.first = first;
      if (pick < 6) begin
         it.func = FUNC_WRITE;
         if ($urandom_range(3) != 0) it.slot = 7'($urandom_range(GLYPH_COUNT - 1));
         return it;
      end
      it.func = FUNC_LAYOUT;
      if (pick < 66) begin
         it.code = 8'(FIRST_PRINTABLE + $urandom_range(GLYPH_COUNT - 1));
      end else if (pick < 80) begin
         it.code = CODE_SPACE;
      end else if (pick < 90) begin
         it.code = CODE_NEWLINE;
      end
      if ($urandom_range(9) != 0) it.mode = 3'($urandom_range(MODE_TINT));
      // keep most strings on screen, let the rest roam the full range
      if ($urandom_range(9) < 7) begin
         it.origin_x = 16'(int'($urandom_range(4000)) - 2000);
         it.origin_y = 16'(int'($urandom_range(4000)) - 2000);
      end
      if ($urandom_range(19) == 0) it.origin_x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      if ($urandom_range(19) == 0) it.origin_y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      return it;
   endfunction

   // Offer one item after a random gap and record its expected result
   task automatic issue_item(input char_item_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it.height, it.width, it.src_y, it.src_x, it.slot, it.tint,
                     it.mode, it.code, it.origin_y, it.origin_x};
      req_tuser  <= {it.first, it.func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_blits.push_back(predict_layout(it));
      items_sent++;
      if (it.func == FUNC_WRITE) table_writes++;
   endtask

   // Stop offering and wait until every result is back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_blits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_GLYPH_SPACING: lay_spacing   = value[5:0];
         CSR_SPACE_ADVANCE: lay_space_adv = value;
         CSR_LINE_HEIGHT:   lay_line_h    = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_layout(input logic [7:0] spacing, input logic [7:0] advance,
                             input logic [7:0] height);
      write_csr(CSR_GLYPH_SPACING, spacing);
      write_csr(CSR_SPACE_ADVANCE, advance);
      write_csr(CSR_LINE_HEIGHT, height);
   endtask

   // One string: starts a new pen position, now and then restarts mid-way
   task automatic send_random_string();
      int len;
      len = $urandom_range(1, 24);
      for (int n = 0; n < len; n++) begin
         issue_item(random_item((n == 0) || ($urandom_range(29) == 0)));
      end
   endtask

   task automatic test_directed();
      char_item_type it;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // untouched table and registers: a glyph draws from an all-zero entry
      issue_item(layout_char(FIRST_PRINTABLE, 1'b1, 16'sd100, 16'sd50, MODE_NORMAL, 16'hFFFF));
      set_layout(8'h30, 8'd0, 8'd255);
      // table entry extremes, then slots past the table
      issue_item(glyph_write(7'd0, 10'd1023, 10'd0, 8'd255, 8'd255));
      issue_item(glyph_write(7'd95, 10'd0, 10'd1023, 8'd1, 8'd8));
      issue_item(glyph_write(7'd96, 10'd17, 10'd17, 8'd17, 8'd17));
      issue_item(glyph_write(7'd127, 10'd9, 10'd9, 8'd9, 8'd9));
      // every blit mode, pen pinned at the right edge
      issue_item(layout_char(FIRST_PRINTABLE, 1'b1, 16'sh7F00, -16'sd5, MODE_NORMAL, 16'h0001));
      for (int m = MODE_KEY; m <= MODE_TINT; m++) begin
         issue_item(layout_char(FIRST_PRINTABLE, 1'b0, '0, '0, 3'(m), 16'h8000));
      end
      // a write with a string start flag leaves the pen alone
      it          = glyph_write(7'd5, 10'd300, 10'd400, 8'd12, 8'd20);
      it.first    = 1'b1;
      it.origin_x = 16'sd1234;
      it.origin_y = 16'sd5678;
      issue_item(it);
      issue_item(layout_char(8'(FIRST_PRINTABLE + 5), 1'b0, '0, '0, MODE_ADD, 16'h1234));
      // unknown modes on the last glyph: advance, no draw
      for (int m = 5; m <= 7; m++) begin
         issue_item(layout_char(8'(FIRST_PRINTABLE + GLYPH_COUNT - 1), 1'b0, '0, '0, 3'(m),
                                16'hABCD));
      end
      // codes with no meaning
      issue_item(layout_char(8'd0, 1'b0, '0, '0, MODE_NORMAL, 16'h0F0F));
      issue_item(layout_char(8'd31, 1'b0, '0, '0, MODE_NORMAL, 16'h0F0F));
      issue_item(layout_char(8'(FIRST_PRINTABLE + GLYPH_COUNT), 1'b0, '0, '0, MODE_NORMAL,
                             16'h0F0F));
      issue_item(layout_char(8'd255, 1'b0, '0, '0, MODE_KEY, 16'h0F0F));
      // space pinned at the left edge, newline pinned at the bottom
      issue_item(layout_char(CODE_SPACE, 1'b1, 16'sh8000, 16'sd32700, MODE_NORMAL, '0));
      issue_item(layout_char(CODE_NEWLINE, 1'b0, '0, '0, MODE_NORMAL, '0));
      issue_item(layout_char(CODE_NEWLINE, 1'b0, '0, '0, MODE_NORMAL, '0));
      issue_item(layout_char(8'(FIRST_PRINTABLE + GLYPH_COUNT - 1), 1'b0, '0, '0, MODE_TINT,
                             16'hFFFF));
   endtask

   // Load a whole font before running text over it
   task automatic test_font_load();
      char_item_type it;
      for (int s = 0; s < GLYPH_COUNT; s++) begin
         it        = random_item(1'b0);
         it.func   = FUNC_WRITE;
         it.slot   = 7'(s);
         it.width  = 8'($urandom_range(2, 24));
         it.height = 8'($urandom_range(6, 32));
         issue_item(it);
      end
   endtask

   task automatic test_layout_extremes();
      int stop_at;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_layout(8'h1F, 8'd255, 8'd0);
      stop_at = items_sent + 100;
      while (items_sent < stop_at) send_random_string();
   endtask

   task automatic test_random_text(input int sender_idle, input int receiver_idle,
                                   input int count);
      int stop_at;
      req_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      set_layout(8'($urandom), 8'($urandom), 8'($urandom));
      stop_at = items_sent + count / 2;
      while (items_sent < stop_at) send_random_string();
      set_layout(8'($urandom), 8'($urandom), 8'($urandom));
      stop_at = items_sent + count - count / 2;
      while (items_sent < stop_at) send_random_string();
   endtask

   // Receiver holds off for a long stretch while the sender keeps pushing
   task automatic test_output_stall();
      int stop_at;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 400;
      stop_at      = items_sent + 120;
      while (items_sent < stop_at) send_random_string();
   endtask

   // Sender pauses after each string until the block is empty
   task automatic test_drain_pause();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      for (int k = 0; k < 6; k++) begin
         send_random_string();
         wait_drain();
      end
   endtask

   // Pace rsp_tready, honoring a requested long hold-off
   always @(posedge clock) begin : rsp_pacing
      int hold_left;
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      blit_type got;
      blit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.draw   = rsp_tuser;
         got.dest_x = rsp_tdata[15:0];
         got.dest_y = rsp_tdata[31:16];
         got.src_x  = rsp_tdata[41:32];
         got.src_y  = rsp_tdata[51:42];
         got.width  = rsp_tdata[59:52];
         got.height = rsp_tdata[67:60];
         got.mode   = rsp_tdata[70:68];
         got.color  = rsp_tdata[86:71];
         if (expected_blits.size() == 0) begin
            if (mismatch_count < REPORT_MAX) begin
               $display("tb_top: unexpected result %s", describe_blit(got));
            end
            mismatch_count++;
         end else begin
            want = expected_blits.pop_front();
            results_checked++;
            if (want.draw) blits_checked++;
            if (got.draw !== want.draw || got.dest_x !== want.dest_x ||
                got.dest_y !== want.dest_y || got.src_x !== want.src_x ||
                got.src_y !== want.src_y || got.width !== want.width ||
                got.height !== want.height || got.mode !== want.mode ||
                got.color !== want.color) begin
               if (mismatch_count < REPORT_MAX) begin
                  $display("tb_top: result %0d mismatch", results_checked);
                  $display("   expected %s", describe_blit(want));
                  $display("   actual   %s", describe_blit(got));
               end
               mismatch_count++;
            end
         end
      end
   end

   // End the run when no handshake completes for too long
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: no progress for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_blits.size());
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin : run
      lay_spacing   = '0;
      lay_space_adv = '0;
      lay_line_h    = '0;
      pen_x         = '0;
      pen_y         = '0;
      line_x        = '0;
      for (int s = 0; s < GLYPH_COUNT; s++) begin
         glyph_sx[s] = '0;
         glyph_sy[s] = '0;
         glyph_w[s]  = '0;
         glyph_h[s]  = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_font_load();
      test_layout_extremes();
      test_random_text(34, 72, 400);
      test_random_text(72, 34, 400);
      test_random_text(0, 0, 400);
      test_output_stall();
      test_drain_pause();
      wait_drain();

      $display("tb_top: %0d items in (%0d glyph writes), %0d results checked, %0d blits",
               items_sent, table_writes, results_checked, blits_checked);
      $display("tb_top: %0d register writes, long output hold-off and drain pauses run",
               csr_writes);
      if (mismatch_count == 0 && expected_blits.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
